[sv/rgb_to_hsl_converter_macros.svh]
// ---------------------------------------------------------------------------
// RGB to HSL converter assertion macros
// Shared forms for the concurrent checks of the converter pipeline.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RGB2HSL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_hsl_converter: check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RGB2HSL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_hsl_converter: check failed");

`endif

[sv/rgb2hsl_pkg.sv]
// ---------------------------------------------------------------------------
// RGB to HSL converter package
// Types, constants and the restoring division step used by the converter.
// ---------------------------------------------------------------------------
package rgb2hsl_pkg;

  localparam int CH_W      = 8;
  localparam int NUM_W     = 17;
  localparam int QUO_W     = 17;
  localparam int HUE_W     = 9;
  localparam int FRAC_W    = 17;
  localparam int DIV_STEPS = 17;

  // Sector of the largest channel.
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  localparam logic [HUE_W-1:0] HUE_FULL_TURN = 9'd360;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] max_ch;
    logic [CH_W-1:0] min_ch;
    logic [1:0]      sector;
  } front_t;

  // One lane of a restoring divider: dividend bits still to shift in,
  // divisor, partial remainder and quotient built so far.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [CH_W-1:0]  den;
    logic [CH_W-1:0]  rem;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t             hue;
    lane_t             sat;
    logic              hue_neg;
    logic              gray;
    logic [FRAC_W-1:0] light;
  } div_stage_t;

  // 60 * x without a multiplier.
  function automatic logic [NUM_W-1:0] times60(logic [CH_W-1:0] x);
    return {3'b0, x, 6'b0} - {7'b0, x, 2'b0};
  endfunction

  // One quotient bit of a restoring division.
  function automatic lane_t div_step(lane_t l);
    logic [CH_W:0] trial;
    logic [CH_W:0] diff;
    lane_t         n;
    trial   = {l.rem, l.num[NUM_W-1]};
    diff    = trial - {1'b0, l.den};
    n       = l;
    n.num   = {l.num[NUM_W-2:0], 1'b0};
    if (trial >= {1'b0, l.den}) begin
      n.rem = diff[CH_W-1:0];
      n.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      n.rem = trial[CH_W-1:0];
      n.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

[sv/rgb_to_hsl_converter.sv]
// ---------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per clock, unless the output stalls, into hue
// in degrees and saturation and lightness as fractions in which 65536 stands for 1.0.
// ---------------------------------------------------------------------------
// The converter takes one pixel per clock cycle unless a stall at the output
// has filled the pipeline. Two front stages find the extreme channels, the
// sector, the divisors and the lightness; two 17-step restoring dividers,
// one quotient bit per register stage, then produce hue and saturation side
// by side; a final stage wraps the hue and registers the result. Each stage
// holds its item until the next one is free, so empty stages fill even while
// a result waits at the output.

`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // hue_degrees [8:0], saturation_frac [25:9],
                                  // lightness_frac [42:26], zeros above
);

  localparam int DS = rgb2hsl_pkg::DIV_STEPS;

  // Front stage: extreme channels and sector.
  logic                 f1_v_r;
  rgb2hsl_pkg::front_t  f1_r;
  rgb2hsl_pkg::front_t  f1_nxt;
  logic                 f1_en;

  // Division stages.
  logic                     dv_v_r [0:DS];
  rgb2hsl_pkg::div_stage_t  dv_r   [0:DS];
  rgb2hsl_pkg::div_stage_t  dv0_nxt;
  logic                     dv_en  [0:DS];

  // Output register.
  logic                                 out_v_r;
  logic [rgb2hsl_pkg::HUE_W-1:0]        hue_r,   hue_nxt;
  logic [rgb2hsl_pkg::FRAC_W-1:0]       sat_r,   sat_nxt;
  logic [rgb2hsl_pkg::FRAC_W-1:0]       light_r, light_nxt;
  logic                                 out_en;

  // ---------------------------------------------------------------------
  // Flow control: a stage may load when it is empty or its successor loads.
  // ---------------------------------------------------------------------
  assign out_en         = !out_v_r || out_tready;
  assign dv_en[DS]      = !dv_v_r[DS] || out_en;
  assign f1_en          = !f1_v_r || dv_en[0];
  assign in_tready      = f1_en;

  for (genvar k = 0; k < DS; k++) begin : g_en
    assign dv_en[k] = !dv_v_r[k] || dv_en[k+1];
  end

  // ---------------------------------------------------------------------
  // Stage 1: maximum, minimum and sector. Ties go to blue, then green.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [7:0] r, g, b, mx, mn;
    r  = in_tdata[7:0];
    g  = in_tdata[15:8];
    b  = in_tdata[23:16];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    f1_nxt.red    = r;
    f1_nxt.green  = g;
    f1_nxt.blue   = b;
    f1_nxt.max_ch = mx;
    f1_nxt.min_ch = mn;
    if (b == mx) begin
      f1_nxt.sector = rgb2hsl_pkg::SEC_BLUE;
    end else if (g == mx) begin
      f1_nxt.sector = rgb2hsl_pkg::SEC_GREEN;
    end else begin
      f1_nxt.sector = rgb2hsl_pkg::SEC_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (f1_en) begin
      f1_v_r <= in_tvalid;
    end
    if (f1_en) begin
      f1_r <= f1_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: divisors, dividends and lightness.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [7:0]  d;
    logic [8:0]  s;
    logic [7:0]  den_sat;
    logic [16:0] hue_num;
    logic        neg;
    logic [15:0] ls;
    logic [16:0] lsum;
    d   = f1_r.max_ch - f1_r.min_ch;
    s   = {1'b0, f1_r.max_ch} + {1'b0, f1_r.min_ch};
    neg = 1'b0;
    // 255 - |s - 255| folds to s below mid-grey and to 510 - s above.
    if (s < 9'd255) begin
      den_sat = s[7:0];
    end else begin
      den_sat = 8'(9'd510 - s);
    end
    case (f1_r.sector)
      rgb2hsl_pkg::SEC_BLUE: begin
        hue_num = rgb2hsl_pkg::times60(f1_r.red)
                + ({1'b0, d, 8'b0} - {5'b0, d, 4'b0})
                - rgb2hsl_pkg::times60(f1_r.green);
      end
      rgb2hsl_pkg::SEC_GREEN: begin
        hue_num = rgb2hsl_pkg::times60(f1_r.blue)
                + ({2'b0, d, 7'b0} - {6'b0, d, 3'b0})
                - rgb2hsl_pkg::times60(f1_r.red);
      end
      rgb2hsl_pkg::SEC_RED: begin
        if (f1_r.green >= f1_r.blue) begin
          hue_num = rgb2hsl_pkg::times60(f1_r.green - f1_r.blue);
        end else begin
          hue_num = rgb2hsl_pkg::times60(f1_r.blue - f1_r.green);
          neg     = 1'b1;
        end
      end
      default: begin
        hue_num = '0;
      end
    endcase
    // Lightness is s * 32768 / 255 = 128 s + floor(128 s / 255); the
    // division by 255 is exact in this add-and-shift form for 128 s < 65536.
    ls   = {s, 7'b0};
    lsum = {1'b0, ls} + 17'd1 + {9'b0, ls[15:8]};

    dv0_nxt.hue.num  = hue_num;
    dv0_nxt.hue.den  = d;
    dv0_nxt.hue.rem  = '0;
    dv0_nxt.hue.quo  = '0;
    // The top bits of d << 16 are below the divisor, so they preload the
    // remainder and only the last seventeen dividend bits need steps.
    dv0_nxt.sat.num  = {d[0], 16'b0};
    dv0_nxt.sat.den  = den_sat;
    dv0_nxt.sat.rem  = {1'b0, d[7:1]};
    dv0_nxt.sat.quo  = '0;
    dv0_nxt.hue_neg  = neg;
    dv0_nxt.gray     = (d == 8'd0);
    dv0_nxt.light    = {1'b0, ls} + {8'b0, lsum[16:8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (dv_en[0]) begin
      dv_v_r[0] <= f1_v_r;
    end
    if (dv_en[0]) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Division stages: one quotient bit for each lane per stage.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < DS; k++) begin : g_div
    rgb2hsl_pkg::div_stage_t step_nxt;

    always_comb begin
      step_nxt     = dv_r[k];
      step_nxt.hue = rgb2hsl_pkg::div_step(dv_r[k].hue);
      step_nxt.sat = rgb2hsl_pkg::div_step(dv_r[k].sat);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (dv_en[k+1]) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      if (dv_en[k+1]) begin
        dv_r[k+1] <= step_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Final stage: wrap a negative red-sector hue and clear grey pixels.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [8:0] q;
    q = dv_r[DS].hue.quo[8:0];
    if (dv_r[DS].gray) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      if (dv_r[DS].hue_neg && (q != 9'd0)) begin
        hue_nxt = rgb2hsl_pkg::HUE_FULL_TURN - q;
      end else begin
        hue_nxt = q;
      end
      sat_nxt = dv_r[DS].sat.quo;
    end
    light_nxt = dv_r[DS].light;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= dv_v_r[DS];
    end
    if (out_en) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      light_r <= light_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, light_r, sat_r, hue_r};

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `RGB2HSL_ASSERT_IMP(a_ready_only_blocked_by_full, !in_tready, f1_v_r && !dv_en[0])
  `RGB2HSL_ASSERT_NXT(a_transfer_enters_front, in_tvalid && in_tready, f1_v_r)
  `RGB2HSL_ASSERT_IMP(a_hue_remainder_bound, dv_v_r[DS] && !dv_r[DS].gray, dv_r[DS].hue.rem < dv_r[DS].hue.den)
  `RGB2HSL_ASSERT_IMP(a_hue_in_range, out_v_r, hue_r < rgb2hsl_pkg::HUE_FULL_TURN)

endmodule
